@@ rtl/bsfb_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfb_pkg
// Shared types and codes for the byte-stuffed frame builder.
// ----------------------------------------------------------------------------
package bsfb_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC    = 2'd2;

  localparam logic [7:0] FLAG_RST   = 8'd126;
  localparam logic [7:0] ESCAPE_RST = 8'd125;
  localparam logic [7:0] SRC_RST    = 8'd0;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] source_addr;
  } bsfb_cfg_t;

  // one accepted item, header length already saturated
  typedef struct packed {
    logic       first;
    logic       fin;
    logic [7:0] frame_index;
    logic [7:0] frame_count;
    logic [7:0] dest_addr;
    logic [3:0] payload_length;
    logic [7:0] payload_byte;
    logic [7:0] check_high;
    logic [7:0] check_low;
  } bsfb_item_t;

  // line byte slots of a frame
  typedef enum logic [3:0] {
    SL_FLAG,
    SL_IDX,
    SL_CNT,
    SL_SRC,
    SL_DST,
    SL_LEN,
    SL_DATA,
    SL_CHKH,
    SL_CHKL,
    SL_CLOSE
  } bsfb_slot_t;

endpackage

@@ rtl/bsfb_front.sv @@
// ----------------------------------------------------------------------------
// bsfb_front
// Accepts input beats, drops bytes outside a frame, tracks the open frame
// and saturates the header length before queueing the item.
// ----------------------------------------------------------------------------
module bsfb_front import bsfb_pkg::*; #(
  parameter int PAYLOAD_MAX = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_first,
  input  logic       in_final_req,
  input  logic [7:0] in_frame_index,
  input  logic [7:0] in_frame_count,
  input  logic [7:0] in_dest_addr,
  input  logic [3:0] in_payload_length,
  input  logic [7:0] in_payload_byte,
  input  logic [7:0] in_check_high,
  input  logic [7:0] in_check_low,
  input  logic       q_full,
  output logic       q_wr_en,
  output bsfb_item_t q_wr_data
);

  logic       in_frame_r, in_frame_nxt;
  logic       accept;
  logic       keep;
  logic [3:0] len_sat;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign keep     = in_first || in_frame_r;
  assign q_wr_en  = accept && keep;

  always_comb begin
    if (int'(in_payload_length) > PAYLOAD_MAX) begin
      len_sat = 4'(PAYLOAD_MAX);
    end else begin
      len_sat = in_payload_length;
    end
  end

  always_comb begin
    q_wr_data.first          = in_first;
    q_wr_data.fin            = in_final_req;
    q_wr_data.frame_index    = in_frame_index;
    q_wr_data.frame_count    = in_frame_count;
    q_wr_data.dest_addr      = in_dest_addr;
    q_wr_data.payload_length = len_sat;
    q_wr_data.payload_byte   = in_payload_byte;
    q_wr_data.check_high     = in_check_high;
    q_wr_data.check_low      = in_check_low;
  end

  // a kept beat opens the frame unless it also closes it
  always_comb begin
    in_frame_nxt = in_frame_r;
    if (q_wr_en) begin
      in_frame_nxt = !in_final_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

@@ rtl/bsfb_queue.sv @@
// ----------------------------------------------------------------------------
// bsfb_queue
// Short item queue between the front and the back end.
// ----------------------------------------------------------------------------
module bsfb_queue import bsfb_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  bsfb_item_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output logic       rd_valid,
  output bsfb_item_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bsfb_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/bsfb_back.sv @@
// ----------------------------------------------------------------------------
// bsfb_back
// Walks the line byte slots of the queued item, inserts escapes and drives
// the output register, one line byte per cycle unless stalled or idle.
// ----------------------------------------------------------------------------
module bsfb_back import bsfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  bsfb_cfg_t  cfg,
  input  logic       hd_valid,
  input  bsfb_item_t hd,
  output logic       hd_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_frame_end
);

  bsfb_slot_t slot_r, slot_nxt;
  bsfb_slot_t cur_slot, succ_slot;
  logic       mid_r, mid_nxt;
  logic       esc_done_r, esc_done_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       run_last_r, frame_end_r;

  logic       go;
  logic [7:0] raw_byte, emit_byte;
  logic       inner, need_esc, last_slot, item_done;

  assign go       = hd_valid && (!out_valid_r || !out_stall);
  assign cur_slot = mid_r ? slot_r : (hd.first ? SL_FLAG : SL_DATA);

  // outputs of the slot sequencer
  always_comb begin
    raw_byte = cfg.flag_value;
    inner    = 1'b1;
    unique case (cur_slot)
      SL_FLAG:  begin raw_byte = cfg.flag_value;   inner = 1'b0; end
      SL_IDX:   raw_byte = hd.frame_index;
      SL_CNT:   raw_byte = hd.frame_count;
      SL_SRC:   raw_byte = cfg.source_addr;
      SL_DST:   raw_byte = hd.dest_addr;
      SL_LEN:   raw_byte = {4'b0000, hd.payload_length};
      SL_DATA:  raw_byte = hd.payload_byte;
      SL_CHKH:  raw_byte = hd.check_high;
      SL_CHKL:  raw_byte = hd.check_low;
      SL_CLOSE: begin raw_byte = cfg.flag_value;   inner = 1'b0; end
      default:  begin raw_byte = cfg.flag_value;   inner = 1'b0; end
    endcase
    need_esc  = inner && !esc_done_r &&
                ((raw_byte == cfg.flag_value) || (raw_byte == cfg.escape_value));
    emit_byte = need_esc ? cfg.escape_value : raw_byte;
    last_slot = (cur_slot == SL_CLOSE) || ((cur_slot == SL_DATA) && !hd.fin);
    item_done = go && !need_esc && last_slot;
    hd_pop    = item_done;
  end

  // next slot
  always_comb begin
    unique case (cur_slot)
      SL_FLAG:  succ_slot = SL_IDX;
      SL_IDX:   succ_slot = SL_CNT;
      SL_CNT:   succ_slot = SL_SRC;
      SL_SRC:   succ_slot = SL_DST;
      SL_DST:   succ_slot = SL_LEN;
      SL_LEN:   succ_slot = SL_DATA;
      SL_DATA:  succ_slot = SL_CHKH;
      SL_CHKH:  succ_slot = SL_CHKL;
      SL_CHKL:  succ_slot = SL_CLOSE;
      SL_CLOSE: succ_slot = SL_FLAG;
      default:  succ_slot = SL_FLAG;
    endcase
    slot_nxt     = slot_r;
    mid_nxt      = mid_r;
    esc_done_nxt = esc_done_r;
    if (go) begin
      if (need_esc) begin
        // hold the slot, send its byte next
        slot_nxt     = cur_slot;
        mid_nxt      = 1'b1;
        esc_done_nxt = 1'b1;
      end else begin
        esc_done_nxt = 1'b0;
        mid_nxt      = !last_slot;
        slot_nxt     = succ_slot;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= SL_FLAG;
      mid_r       <= 1'b0;
      esc_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      mid_r       <= mid_nxt;
      esc_done_r  <= esc_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_byte_r  <= emit_byte;
      run_last_r  <= item_done;
      frame_end_r <= !need_esc && (cur_slot == SL_CLOSE);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

endmodule

@@ rtl/byte_stuffed_frame_builder.sv @@
// ----------------------------------------------------------------------------
// byte_stuffed_frame_builder
// Wraps runs of payload bytes in flag-delimited frames with a five byte
// header and two check bytes, escaping inner flag and escape bytes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat
//  in_     | in        | in_valid/in_stall  | one payload byte with marks
//  out_    | out       | out_valid/out_stall| one line byte
//  cfg_    | in        | cfg_valid/cfg_ready| register index and data
//
//  The back end sends one line byte per cycle while an item is queued and
//  the output is not stalled; an escape adds one line byte before the byte
//  it escapes. Bytes outside a frame are dropped without being queued.
//  Reset is synchronous; it closes any open frame and empties the queue.
//  Input is stalled only while the two-entry queue is full; output stall
//  holds the output register and the sequencer.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_builder import bsfb_pkg::*; #(
  parameter int PAYLOAD_MAX = 8,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_first,
  input  logic                 in_final_req,
  input  logic [7:0]           in_frame_index,
  input  logic [7:0]           in_frame_count,
  input  logic [7:0]           in_dest_addr,
  input  logic [3:0]           in_payload_length,
  input  logic [7:0]           in_payload_byte,
  input  logic [7:0]           in_check_high,
  input  logic [7:0]           in_check_low,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_run_last,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  bsfb_cfg_t  cfg_r, cfg_nxt;
  logic       q_wr_en, q_full, q_rd_en, q_rd_valid;
  bsfb_item_t q_wr_data, q_rd_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FLAG:   cfg_nxt.flag_value   = cfg_data;
        CFG_ESCAPE: cfg_nxt.escape_value = cfg_data;
        CFG_SRC:    cfg_nxt.source_addr  = cfg_data;
        default:    cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_value   <= FLAG_RST;
      cfg_r.escape_value <= ESCAPE_RST;
      cfg_r.source_addr  <= SRC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bsfb_front #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_first          (in_first),
    .in_final_req      (in_final_req),
    .in_frame_index    (in_frame_index),
    .in_frame_count    (in_frame_count),
    .in_dest_addr      (in_dest_addr),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .in_check_high     (in_check_high),
    .in_check_low      (in_check_low),
    .q_full            (q_full),
    .q_wr_en           (q_wr_en),
    .q_wr_data         (q_wr_data)
  );

  bsfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr_en),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_en    (q_rd_en),
    .rd_valid (q_rd_valid),
    .rd_data  (q_rd_data)
  );

  bsfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .hd_valid      (q_rd_valid),
    .hd            (q_rd_data),
    .hd_pop        (q_rd_en),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule

@@ rtl/bsfb_checker.sv @@
// ----------------------------------------------------------------------------
// bsfb_checker
// Port-level checks on the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module bsfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_frame_end,
  input logic       cfg_ready
);

  // the closing flag always ends the run of its beat
  a_close_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_run_last)
    else $error("closing flag without run_last");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_run_last) && $stable(out_frame_end))
    else $error("stalled output beat changed");

  // reset clears the output and leaves the input unstalled
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // the configuration port always takes a write
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind byte_stuffed_frame_builder bsfb_checker u_bsfb_checker (.*);
